/* hw/rtl/sorted_priority_queue_macros.svh */
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTH
`define SPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sorted priority queue check failed");
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted priority queue check failed");
`else
`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/spq_pkg.sv */
// package with types and constants of the sorted priority queue
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned OCC_W       = 5;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e  cmd;
    word_t value;
    word_t priority_req;
  } in_t;

  typedef struct packed {
    status_e          status;
    word_t            out_value;
    word_t            out_priority;
    logic [OCC_W-1:0] occupancy;
  } out_t;

  typedef struct packed {
    logic  ins;
    logic  del;
    word_t value;
    word_t prio;
  } cell_ctrl_t;

endpackage

/* hw/rtl/spq_cell.sv */
// one queue slot: holds an entry and moves it toward the head or the tail
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       prev_valid_i,
  input  logic       prev_shift_i,
  input  word_t      prev_value_i,
  input  word_t      prev_prio_i,
  input  logic       next_valid_i,
  input  word_t      next_value_i,
  input  word_t      next_prio_i,
  output logic       valid_o,
  output logic       shift_o,
  output word_t      value_o,
  output word_t      prio_o
);

  logic  valid_q, valid_d;
  word_t value_q, value_d;
  word_t prio_q, prio_d;

  // entry moves one slot toward the tail when the new key is strictly smaller
  assign shift_o = valid_q && (ctrl_i.prio < prio_q);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    prio_d  = prio_q;
    if (ctrl_i.ins) begin
      if (prev_shift_i) begin
        valid_d = 1'b1;
        value_d = prev_value_i;
        prio_d  = prev_prio_i;
      end else if (prev_valid_i && (shift_o || !valid_q)) begin
        valid_d = 1'b1;
        value_d = ctrl_i.value;
        prio_d  = ctrl_i.prio;
      end
    end else if (ctrl_i.del) begin
      valid_d = next_valid_i;
      value_d = next_value_i;
      prio_d  = next_prio_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// sorted min-priority queue built from a row of shifting slots
// result strobe follows in the cycle after the command transfer
// throughput: one command every cycle, busy stays low; set by the slot row, whose slots all update together
// reset: asynchronous, active low; empties the queue, slot payload is not cleared
// the receiver cannot stall: each result is strobed on done_o for exactly one cycle
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output logic done_o,
  output out_t result_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            accept, full, empty, do_ins, do_del;
  cell_ctrl_t      ctrl;
  logic            done_q;
  out_t            result_q, result_d;

  logic  [QueueDepth-1:0] valid_vec, shift_vec;
  word_t                  value_arr [QueueDepth];
  word_t                  prio_arr  [QueueDepth];
  logic  [QueueDepth-1:1] order_ok;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntW'(QueueDepth));
  assign empty  = (count_q == '0);
  assign do_ins = accept && (in_i.cmd == CMD_INSERT) && !full;
  assign do_del = accept && (in_i.cmd == CMD_DELETE) && !empty;

  assign ctrl.ins   = do_ins;
  assign ctrl.del   = do_del;
  assign ctrl.value = in_i.value;
  assign ctrl.prio  = in_i.priority_req;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic  prev_valid, prev_shift, next_valid;
    word_t prev_value, prev_prio, next_value, next_prio;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_shift = 1'b0;
      assign prev_value = '0;
      assign prev_prio  = '0;
    end else begin : g_mid
      assign prev_valid = valid_vec[i-1];
      assign prev_shift = shift_vec[i-1];
      assign prev_value = value_arr[i-1];
      assign prev_prio  = prio_arr[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_value = '0;
      assign next_prio  = '0;
    end else begin : g_body
      assign next_valid = valid_vec[i+1];
      assign next_value = value_arr[i+1];
      assign next_prio  = prio_arr[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_valid_i(prev_valid),
      .prev_shift_i(prev_shift),
      .prev_value_i(prev_value),
      .prev_prio_i (prev_prio),
      .next_valid_i(next_valid),
      .next_value_i(next_value),
      .next_prio_i (next_prio),
      .valid_o     (valid_vec[i]),
      .shift_o     (shift_vec[i]),
      .value_o     (value_arr[i]),
      .prio_o      (prio_arr[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + 1'b1;
    end else if (do_del) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    result_d              = '0;
    result_d.status       = STATUS_OK;
    result_d.occupancy    = OCC_W'(count_d);
    if (in_i.cmd == CMD_DELETE) begin
      if (empty) begin
        result_d.status = STATUS_UNDERFLOW;
      end else begin
        result_d.out_value    = value_arr[0];
        result_d.out_priority = prio_arr[0];
      end
    end else if (full) begin
      result_d.status = STATUS_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // occupied slots form a prefix sorted by priority
  always_comb begin
    for (int i = 1; i < QueueDepth; i++) begin
      order_ok[i] = !valid_vec[i] || (valid_vec[i-1] && (prio_arr[i-1] <= prio_arr[i]));
    end
  end

  `SPQ_ASSERT(a_prefix_sorted, &order_ok)
  `SPQ_ASSERT(a_count_matches, $countones(valid_vec) == 32'(count_q))
  `SPQ_ASSERT_NEXT(a_strobe_follows, accept, done_o)
  `SPQ_ASSERT_NEXT(a_full_drop, do_ins == 1'b0 && accept && in_i.cmd == CMD_INSERT,
                   result_o.status == STATUS_FULL && $stable(count_q))
  `SPQ_ASSERT_NEXT(a_delete_head, do_del, result_o.out_priority == $past(prio_arr[0]))

endmodule
